// ===== hdl/lgs_pkg.sv =====
// Package for the life grid generation step block.
// Sizes, codes, word types and the shade table, shared by all modules in hdl/.
// No dependencies.
package lgs_pkg;

   localparam int MAX_WIDTH  = 32;
   localparam int MAX_HEIGHT = 32;
   localparam int COL_AW     = $clog2(MAX_WIDTH);
   localparam int ROW_AW     = $clog2(MAX_HEIGHT);
   // row index in "row plus one" form, so that the row above row 0 is representable
   localparam int IDX_W      = ROW_AW + 1;
   localparam int NUM_BANKS  = 3;
   localparam int BANK_AW    = $clog2(NUM_BANKS);
   localparam int MEM_AW     = BANK_AW + ROW_AW;
   localparam int MEM_DEPTH  = NUM_BANKS * MAX_HEIGHT;

   localparam int CFG_W      = 6;
   localparam int CFG_AW     = 1;
   localparam int GRID_RESET = 32;
   localparam int CNT_W      = 4;
   localparam int SHADE_W    = 8;

   localparam int BIRTH_COUNT   = 3;
   localparam int SURVIVE_COUNT = 2;

   localparam logic [CFG_AW-1:0] CSR_GRID_WIDTH  = 1'b0;
   localparam logic [CFG_AW-1:0] CSR_GRID_HEIGHT = 1'b1;

   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_STEP  = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   localparam logic [BANK_AW-1:0] BANK_CUR_RESET  = 2'd0;
   localparam logic [BANK_AW-1:0] BANK_PREV_RESET = 2'd1;
   localparam logic [BANK_AW-1:0] BANK_NEXT_RESET = 2'd2;

   typedef logic [MAX_WIDTH-1:0] row_type;

   typedef struct packed {
      logic [1:0]        op;
      logic [COL_AW-1:0] col;
      logic [ROW_AW-1:0] row;
      logic              cell_value;
   } req_type;

   typedef struct packed {
      logic               alive;
      logic [CNT_W-1:0]   neighbor_count;
      logic [SHADE_W-1:0] shade;
      logic               stuck;
   } rsp_type;

   typedef struct packed {
      logic              en;
      logic [MEM_AW-1:0] addr;
      row_type           data;
   } mem_wr_type;

   function automatic logic [SHADE_W-1:0] shade_of(input logic [CNT_W-1:0] n);
      logic [SHADE_W-1:0] s;
      unique case (n)
         4'd0:    s = 8'd1;
         4'd1:    s = 8'd5;
         4'd2:    s = 8'd10;
         4'd3:    s = 8'd20;
         4'd4:    s = 8'd40;
         4'd5:    s = 8'd80;
         4'd6:    s = 8'd160;
         4'd7:    s = 8'd200;
         4'd8:    s = 8'd250;
         default: s = 8'd0;
      endcase
      return s;
   endfunction

endpackage

// ===== hdl/lgs_row_mem.sv =====
// Row store for the three grid banks (previous, current, next).
// One write port, two read ports with registered read data. Uses lgs_pkg.
module lgs_row_mem (
   input  logic                              clock,
   input  lgs_pkg::mem_wr_type               wr,
   input  logic [lgs_pkg::MEM_AW-1:0]        rd_a_addr,
   input  logic [lgs_pkg::MEM_AW-1:0]        rd_b_addr,
   output lgs_pkg::row_type                  rd_a_data,
   output lgs_pkg::row_type                  rd_b_data
);

   lgs_pkg::row_type mem [lgs_pkg::MEM_DEPTH];
   lgs_pkg::row_type rd_a_ff;
   lgs_pkg::row_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_a_ff <= mem[rd_a_addr];
      rd_b_ff <= mem[rd_b_addr];
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

// ===== hdl/lgs_row_unit.sv =====
// Row evaluation unit: neighbour counts and B3/S23 next state for a whole row.
// Fed from the three-row window; shared by step sweeps and cell reads. Uses lgs_pkg.
module lgs_row_unit (
   input  lgs_pkg::row_type                  above,
   input  lgs_pkg::row_type                  middle,
   input  lgs_pkg::row_type                  below,
   input  logic [lgs_pkg::COL_AW-1:0]        sel_col,
   output lgs_pkg::row_type                  next_row,
   output logic [lgs_pkg::CNT_W-1:0]         sel_count
);

   // zero padding either side: columns off the edge are dead
   logic [lgs_pkg::MAX_WIDTH+1:0] up_p;
   logic [lgs_pkg::MAX_WIDTH+1:0] mid_p;
   logic [lgs_pkg::MAX_WIDTH+1:0] dn_p;
   logic [lgs_pkg::CNT_W-1:0]     cnt [lgs_pkg::MAX_WIDTH];

   always_comb begin
      up_p  = {1'b0, above, 1'b0};
      mid_p = {1'b0, middle, 1'b0};
      dn_p  = {1'b0, below, 1'b0};
      for (int i = 0; i < lgs_pkg::MAX_WIDTH; i++) begin
         cnt[i] = lgs_pkg::CNT_W'(up_p[i]) + lgs_pkg::CNT_W'(up_p[i+1])
                + lgs_pkg::CNT_W'(up_p[i+2]) + lgs_pkg::CNT_W'(mid_p[i])
                + lgs_pkg::CNT_W'(mid_p[i+2]) + lgs_pkg::CNT_W'(dn_p[i])
                + lgs_pkg::CNT_W'(dn_p[i+1]) + lgs_pkg::CNT_W'(dn_p[i+2]);
         if (middle[i]) begin
            next_row[i] = (cnt[i] == lgs_pkg::CNT_W'(lgs_pkg::SURVIVE_COUNT))
                       || (cnt[i] == lgs_pkg::CNT_W'(lgs_pkg::BIRTH_COUNT));
         end else begin
            next_row[i] = (cnt[i] == lgs_pkg::CNT_W'(lgs_pkg::BIRTH_COUNT));
         end
      end
   end

   assign sel_count = cnt[sel_col];

endmodule

// ===== hdl/life_grid_generation_step.sv =====
// Top level of the life grid block: sequencer, bank pointers and row valid bits.
// Instantiates lgs_row_mem and lgs_row_unit; uses lgs_pkg.
//
// Usage:
//   Command word on req_item is taken at a clock edge with start high and busy low.
//   Exactly one result word per command appears on rsp_item with rsp_valid high
//   for a single cycle; there is no back-pressure, the receiver must take it.
//   csr_write_en/csr_index/csr_wdata write grid_width (index 0) and grid_height
//   (index 1); write only while busy is low and no result is pending.
// Sequence per command (from accept to the edge that takes the result):
//   write cell    row fetched, then written back (result registered at accept if outside grid)
//   read cell     three row fetches (above, at, below) on one memory read port
//   step          a priming fetch, then one row per cycle through the shared
//                 row unit, with current and previous rows fetched together
//   unused op     result registered at accept
//   busy falls in the cycle the result is shown, so the next command can be
//   taken at the same edge that takes the result.
// Reset (synchronous): grid size back to 32 x 32, every row of every bank marked
//   empty so all cells read dead at once; no clearing pass.
module life_grid_generation_step (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  lgs_pkg::req_type             req_item,
   output logic                         rsp_valid,
   output lgs_pkg::rsp_type             rsp_item,
   input  logic                         csr_write_en,
   input  logic [lgs_pkg::CFG_AW-1:0]   csr_index,
   input  logic [lgs_pkg::CFG_W-1:0]    csr_wdata
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_WR_MOD,
      S_RD_UP,
      S_RD_MID,
      S_RD_OUT,
      S_ST_PRIME,
      S_ST_SWEEP
   } state_type;

   state_type                       state_ff;
   logic                            rsp_valid_ff;
   lgs_pkg::rsp_type                rsp_item_ff;
   logic [lgs_pkg::CFG_W-1:0]       w_ff;
   logic [lgs_pkg::CFG_W-1:0]       h_ff;
   logic [lgs_pkg::BANK_AW-1:0]     cur_bank_ff;
   logic [lgs_pkg::BANK_AW-1:0]     prev_bank_ff;
   logic [lgs_pkg::BANK_AW-1:0]     next_bank_ff;
   logic [lgs_pkg::MAX_HEIGHT-1:0]  valid_ff [lgs_pkg::NUM_BANKS];
   logic                            a_ok_ff;
   logic                            b_ok_ff;
   logic                            same_cur_ff;
   logic                            same_prev_ff;
   logic [lgs_pkg::ROW_AW-1:0]      y_ff;
   logic [lgs_pkg::COL_AW-1:0]      col_ff;
   logic [lgs_pkg::ROW_AW-1:0]      row_ff;
   logic                            value_ff;
   lgs_pkg::row_type                up_ff;
   lgs_pkg::row_type                mid_ff;

   logic                            accept;
   logic [lgs_pkg::CFG_W-1:0]       used_w;
   logic [lgs_pkg::CFG_W-1:0]       used_h;
   lgs_pkg::row_type                col_mask;
   logic                            wr_in_area;
   logic [lgs_pkg::IDX_W-1:0]       a_idx;
   logic [lgs_pkg::IDX_W-1:0]       a_idx_m1;
   logic [lgs_pkg::IDX_W-1:0]       b_row;
   logic [lgs_pkg::MEM_AW-1:0]      a_addr;
   logic [lgs_pkg::MEM_AW-1:0]      b_addr;
   logic                            a_ok_in;
   logic                            b_ok_in;
   lgs_pkg::row_type                rd_a_data;
   lgs_pkg::row_type                rd_b_data;
   lgs_pkg::row_type                a_row_raw;
   lgs_pkg::row_type                a_row_m;
   lgs_pkg::row_type                b_row_m;
   lgs_pkg::row_type                unit_next;
   lgs_pkg::row_type                next_row_m;
   lgs_pkg::row_type                wr_row;
   logic [lgs_pkg::CNT_W-1:0]       sel_count;
   lgs_pkg::mem_wr_type             mem_wr;
   logic                            same_cur_in;
   logic                            same_prev_in;
   logic                            last_row;
   lgs_pkg::rsp_type                read_rsp;
   lgs_pkg::rsp_type                step_rsp;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   // size registers: 0 acts as 1, anything above the maximum acts as the maximum
   always_comb begin
      if (w_ff == '0) begin
         used_w = lgs_pkg::CFG_W'(1);
      end else if (w_ff > lgs_pkg::CFG_W'(lgs_pkg::MAX_WIDTH)) begin
         used_w = lgs_pkg::CFG_W'(lgs_pkg::MAX_WIDTH);
      end else begin
         used_w = w_ff;
      end
      if (h_ff == '0) begin
         used_h = lgs_pkg::CFG_W'(1);
      end else if (h_ff > lgs_pkg::CFG_W'(lgs_pkg::MAX_HEIGHT)) begin
         used_h = lgs_pkg::CFG_W'(lgs_pkg::MAX_HEIGHT);
      end else begin
         used_h = h_ff;
      end
      for (int i = 0; i < lgs_pkg::MAX_WIDTH; i++) begin
         col_mask[i] = (lgs_pkg::CFG_W'(i) < used_w);
      end
   end

   assign wr_in_area = (lgs_pkg::CFG_W'(req_item.col) < used_w)
                    && (lgs_pkg::CFG_W'(req_item.row) < used_h);

   // read port A always fetches from the current bank, port B from the previous
   always_comb begin
      a_idx = '0;
      b_row = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_item.op == lgs_pkg::OP_WRITE) begin
               a_idx = lgs_pkg::IDX_W'(req_item.row) + lgs_pkg::IDX_W'(1);
            end else if (req_item.op == lgs_pkg::OP_READ) begin
               a_idx = lgs_pkg::IDX_W'(req_item.row);
            end else begin
               a_idx = lgs_pkg::IDX_W'(1);
            end
         end
         S_RD_UP:    a_idx = lgs_pkg::IDX_W'(row_ff) + lgs_pkg::IDX_W'(1);
         S_RD_MID:   a_idx = lgs_pkg::IDX_W'(row_ff) + lgs_pkg::IDX_W'(2);
         S_ST_PRIME: begin
            a_idx = lgs_pkg::IDX_W'(2);
            b_row = '0;
         end
         S_ST_SWEEP: begin
            a_idx = lgs_pkg::IDX_W'(y_ff) + lgs_pkg::IDX_W'(3);
            b_row = lgs_pkg::IDX_W'(y_ff) + lgs_pkg::IDX_W'(1);
         end
         default: begin
            a_idx = '0;
            b_row = '0;
         end
      endcase
   end

   assign a_idx_m1 = a_idx - lgs_pkg::IDX_W'(1);
   assign a_addr   = {cur_bank_ff, a_idx_m1[lgs_pkg::ROW_AW-1:0]};
   assign b_addr   = {prev_bank_ff, b_row[lgs_pkg::ROW_AW-1:0]};
   assign a_ok_in  = (a_idx != '0) && (a_idx <= lgs_pkg::IDX_W'(used_h))
                  && valid_ff[cur_bank_ff][a_idx_m1[lgs_pkg::ROW_AW-1:0]];
   assign b_ok_in  = (b_row < lgs_pkg::IDX_W'(used_h))
                  && valid_ff[prev_bank_ff][b_row[lgs_pkg::ROW_AW-1:0]];

   lgs_row_mem u_mem (
      .clock     (clock),
      .wr        (mem_wr),
      .rd_a_addr (a_addr),
      .rd_b_addr (b_addr),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data)
   );

   // raw row keeps cells outside the area for the write path; masked for evaluation
   assign a_row_raw = a_ok_ff ? rd_a_data : '0;
   assign a_row_m   = a_row_raw & col_mask;
   assign b_row_m   = b_ok_ff ? (rd_b_data & col_mask) : '0;

   lgs_row_unit u_unit (
      .above     (up_ff),
      .middle    (mid_ff),
      .below     (a_row_m),
      .sel_col   (col_ff),
      .next_row  (unit_next),
      .sel_count (sel_count)
   );

   assign next_row_m   = unit_next & col_mask;
   assign same_cur_in  = same_cur_ff && (next_row_m == mid_ff);
   assign same_prev_in = same_prev_ff && (next_row_m == b_row_m);
   assign last_row     = (lgs_pkg::IDX_W'(y_ff) + lgs_pkg::IDX_W'(1))
                      == lgs_pkg::IDX_W'(used_h);

   assign wr_row = (a_row_raw & ~(lgs_pkg::row_type'(1) << col_ff))
                 | (lgs_pkg::row_type'(value_ff) << col_ff);

   always_comb begin
      mem_wr = '0;
      if (state_ff == S_WR_MOD) begin
         mem_wr.en   = 1'b1;
         mem_wr.addr = {cur_bank_ff, row_ff};
         mem_wr.data = wr_row;
      end else if (state_ff == S_ST_SWEEP) begin
         mem_wr.en   = 1'b1;
         mem_wr.addr = {next_bank_ff, y_ff};
         mem_wr.data = next_row_m;
      end
   end

   always_comb begin
      read_rsp                = '0;
      read_rsp.alive          = mid_ff[col_ff];
      read_rsp.neighbor_count = sel_count;
      read_rsp.shade          = mid_ff[col_ff] ? lgs_pkg::shade_of(sel_count) : '0;
   end

   always_comb begin
      step_rsp       = '0;
      step_rsp.stuck = same_cur_in || same_prev_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         w_ff         <= lgs_pkg::CFG_W'(lgs_pkg::GRID_RESET);
         h_ff         <= lgs_pkg::CFG_W'(lgs_pkg::GRID_RESET);
         cur_bank_ff  <= lgs_pkg::BANK_CUR_RESET;
         prev_bank_ff <= lgs_pkg::BANK_PREV_RESET;
         next_bank_ff <= lgs_pkg::BANK_NEXT_RESET;
         for (int b = 0; b < lgs_pkg::NUM_BANKS; b++) begin
            valid_ff[b] <= '0;
         end
      end else begin
         rsp_valid_ff <= 1'b0;
         a_ok_ff      <= a_ok_in;
         b_ok_ff      <= b_ok_in;
         if (csr_write_en) begin
            unique case (csr_index)
               lgs_pkg::CSR_GRID_WIDTH:  w_ff <= csr_wdata;
               lgs_pkg::CSR_GRID_HEIGHT: h_ff <= csr_wdata;
            endcase
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  col_ff   <= req_item.col;
                  row_ff   <= req_item.row;
                  value_ff <= req_item.cell_value;
                  unique case (req_item.op)
                     lgs_pkg::OP_WRITE: begin
                        if (wr_in_area) begin
                           state_ff <= S_WR_MOD;
                        end else begin
                           rsp_valid_ff <= 1'b1;
                           rsp_item_ff  <= '0;
                        end
                     end
                     lgs_pkg::OP_STEP: begin
                        valid_ff[next_bank_ff] <= '0;
                        same_cur_ff            <= 1'b1;
                        same_prev_ff           <= 1'b1;
                        y_ff                   <= '0;
                        state_ff               <= S_ST_PRIME;
                     end
                     lgs_pkg::OP_READ: begin
                        state_ff <= S_RD_UP;
                     end
                     default: begin
                        rsp_valid_ff <= 1'b1;
                        rsp_item_ff  <= '0;
                     end
                  endcase
               end
            end
            S_WR_MOD: begin
               valid_ff[cur_bank_ff][row_ff] <= 1'b1;
               rsp_valid_ff                  <= 1'b1;
               rsp_item_ff                   <= '0;
               state_ff                      <= S_IDLE;
            end
            S_RD_UP: begin
               up_ff    <= a_row_m;
               state_ff <= S_RD_MID;
            end
            S_RD_MID: begin
               mid_ff   <= a_row_m;
               state_ff <= S_RD_OUT;
            end
            S_RD_OUT: begin
               rsp_valid_ff <= 1'b1;
               rsp_item_ff  <= read_rsp;
               state_ff     <= S_IDLE;
            end
            S_ST_PRIME: begin
               up_ff    <= '0;
               mid_ff   <= a_row_m;
               state_ff <= S_ST_SWEEP;
            end
            S_ST_SWEEP: begin
               valid_ff[next_bank_ff][y_ff] <= 1'b1;
               up_ff                        <= mid_ff;
               mid_ff                       <= a_row_m;
               same_cur_ff                  <= same_cur_in;
               same_prev_ff                 <= same_prev_in;
               y_ff                         <= y_ff + lgs_pkg::ROW_AW'(1);
               if (last_row) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_item_ff  <= step_rsp;
                  // new grid kept: rotate roles instead of copying rows
                  if (!(same_cur_in || same_prev_in)) begin
                     prev_bank_ff <= cur_bank_ff;
                     cur_bank_ff  <= next_bank_ff;
                     next_bank_ff <= prev_bank_ff;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

`ifndef SYNTHESIS
   a_bank_roles_distinct: assert property (@(posedge clock) disable iff (reset)
      (cur_bank_ff != prev_bank_ff) && (cur_bank_ff != next_bank_ff)
      && (prev_bank_ff != next_bank_ff))
      else $error("grid bank roles overlap");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept && (req_item.op == lgs_pkg::OP_STEP) |=> busy)
      else $error("step word accepted but block not busy");

   a_result_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result word shown while still busy");

   a_stuck_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.stuck |-> !rsp_item.alive && (rsp_item.neighbor_count == '0)
      && (rsp_item.shade == '0))
      else $error("stuck flag mixed with read fields");
`endif

endmodule
